[hdl/fbb_pkg.sv]
`timescale 1ns / 1ps
// Package for the frustum bounding box block: payload structs, register codes,
// fixed-point format and the saturating helpers. No dependencies.
package fbb_pkg;

    // Fixed-point format
    localparam int FRAC_BITS  = 16;
    localparam int Q_W        = 32;
    localparam int REG_W      = 31;
    localparam int PROD_W     = 2 * Q_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Pipeline depth, output register included
    localparam int NUM_STAGES = 7;

    // Register reset values: 1.0, 100.0, 1.0, 1.0
    localparam logic [REG_W-1:0] NEAR_RESET  = REG_W'(64'd1 << FRAC_BITS);
    localparam logic [REG_W-1:0] FAR_RESET   = REG_W'(64'd100 << FRAC_BITS);
    localparam logic [REG_W-1:0] TAN_H_RESET = REG_W'(64'd1 << FRAC_BITS);
    localparam logic [REG_W-1:0] TAN_W_RESET = REG_W'(64'd1 << FRAC_BITS);

    // Saturation limits
    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR  = 8'd0,
        REG_FAR   = 8'd1,
        REG_TAN_H = 8'd2,
        REG_TAN_W = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [Q_W-1:0] pos_x;
        logic signed [Q_W-1:0] pos_y;
        logic signed [Q_W-1:0] pos_z;
        logic signed [Q_W-1:0] up_x;
        logic signed [Q_W-1:0] up_y;
        logic signed [Q_W-1:0] up_z;
        logic signed [Q_W-1:0] fwd_x;
        logic signed [Q_W-1:0] fwd_y;
        logic signed [Q_W-1:0] fwd_z;
    } cam_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] min_x;
        logic signed [Q_W-1:0] min_y;
        logic signed [Q_W-1:0] min_z;
        logic signed [Q_W-1:0] max_x;
        logic signed [Q_W-1:0] max_y;
        logic signed [Q_W-1:0] max_z;
    } box_item_t;

    // Floor shift of an exact product (or product difference), then saturate
    function automatic logic signed [Q_W-1:0] sat_shift(input logic signed [PROD_W:0] v);
        logic signed [PROD_W:0] s;
        logic signed [PROD_W:0] hi_lim;
        logic signed [PROD_W:0] lo_lim;
        s      = v >>> FRAC_BITS;
        hi_lim = (PROD_W+1)'(Q_MAX);
        lo_lim = (PROD_W+1)'(Q_MIN);
        if (s > hi_lim)
            return Q_MAX;
        else if (s < lo_lim)
            return Q_MIN;
        else
            return s[Q_W-1:0];
    endfunction

    // Saturate a short sum of up to three Q values
    function automatic logic signed [Q_W-1:0] sat_sum(input logic signed [Q_W+1:0] v);
        logic signed [Q_W+1:0] hi_lim;
        logic signed [Q_W+1:0] lo_lim;
        hi_lim = (Q_W+2)'(Q_MAX);
        lo_lim = (Q_W+2)'(Q_MIN);
        if (v > hi_lim)
            return Q_MAX;
        else if (v < lo_lim)
            return Q_MIN;
        else
            return v[Q_W-1:0];
    endfunction

endpackage

[hdl/frustum_bounding_box_top.sv]
`timescale 1ns / 1ps
// Frustum bounding box: pipeline from camera pose to box.
// Depends on fbb_pkg for payload structs, register codes and saturation helpers.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one camera item:
//   position, up and forward vectors in signed Q16.16. Output channel
//   (out_valid / out_stall / out_data) returns one box item per camera item:
//   the min and max corner of the eight frustum corners, saturated.
//   Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   near, far, tan_half_height, tan_half_width; cfg_ready is always high and
//   writes to unknown indexes are dropped. Write only while the block is idle.
// Flow and stages:
//   an accepted item passes through every stage register in order before out_valid
//   rises; one item per cycle sustained while out_stall is low.
//   The stages are: products, cross/centre reduction, offset products,
//   product saturation, corner sums, two levels of min/max, the final min/max
//   into the output register. The 32x32 multipliers of stages 0 and 2
//   set the cycle time.
// Reset and stall:
//   rst_n clears all stage valid bits and loads the register reset values.
//   While out_stall holds a result, a stage holds its item unless a later one is
//   empty; empty stages still fill, and in_stall rises only when all are occupied.
module frustum_bounding_box_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  fbb_pkg::cam_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output fbb_pkg::box_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fbb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int QW = fbb_pkg::Q_W;
    localparam int PW = fbb_pkg::PROD_W;
    localparam int NS = fbb_pkg::NUM_STAGES;

    // Configuration registers
    logic [fbb_pkg::REG_W-1:0] near_reg, far_reg, tan_h_reg, tan_w_reg;

    // Stage control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // Stage 0: raw products
    logic signed [PW-1:0] cx_next  [6];
    logic signed [PW-1:0] cx_reg   [6];
    logic signed [PW-1:0] fd_next  [2][3];
    logic signed [PW-1:0] fd_reg   [2][3];
    logic signed [PW-1:0] ofl_next [2];
    logic signed [PW-1:0] ofl_reg  [2];
    logic signed [PW-1:0] ofu_next [2];
    logic signed [PW-1:0] ofu_reg  [2];
    logic signed [QW-1:0] pos0_next [3];
    logic signed [QW-1:0] pos0_reg  [3];
    logic signed [QW-1:0] up0_next  [3];
    logic signed [QW-1:0] up0_reg   [3];

    // Stage 1: left vector, plane centres, offsets
    logic signed [QW-1:0] left1_next [3];
    logic signed [QW-1:0] left1_reg  [3];
    logic signed [QW-1:0] cen1_next  [2][3];
    logic signed [QW-1:0] cen1_reg   [2][3];
    logic signed [QW-1:0] offl1_next [2];
    logic signed [QW-1:0] offl1_reg  [2];
    logic signed [QW-1:0] offu1_next [2];
    logic signed [QW-1:0] offu1_reg  [2];
    logic signed [QW-1:0] up1_reg    [3];

    // Stage 2: offset products
    logic signed [PW-1:0] ltp2_next [2][3];
    logic signed [PW-1:0] ltp2_reg  [2][3];
    logic signed [PW-1:0] utp2_next [2][3];
    logic signed [PW-1:0] utp2_reg  [2][3];
    logic signed [QW-1:0] cen2_reg  [2][3];

    // Stage 3: saturated offset terms
    logic signed [QW-1:0] lt3_next [2][3];
    logic signed [QW-1:0] lt3_reg  [2][3];
    logic signed [QW-1:0] ut3_next [2][3];
    logic signed [QW-1:0] ut3_reg  [2][3];
    logic signed [QW-1:0] cen3_reg [2][3];

    // Stage 4: corners, index p*4 + sl*2 + su
    logic signed [QW-1:0] cor4_next [3][8];
    logic signed [QW-1:0] cor4_reg  [3][8];

    // Stage 5: partial min/max, two per axis
    logic signed [QW-1:0] lo5_next [3][2];
    logic signed [QW-1:0] lo5_reg  [3][2];
    logic signed [QW-1:0] hi5_next [3][2];
    logic signed [QW-1:0] hi5_reg  [3][2];

    // Stage 6: output register
    fbb_pkg::box_item_t out_data_next;
    fbb_pkg::box_item_t out_data_reg;

    // Write configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg  <= fbb_pkg::NEAR_RESET;
            far_reg   <= fbb_pkg::FAR_RESET;
            tan_h_reg <= fbb_pkg::TAN_H_RESET;
            tan_w_reg <= fbb_pkg::TAN_W_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fbb_pkg::REG_NEAR:  near_reg  <= cfg_data[fbb_pkg::REG_W-1:0];
                fbb_pkg::REG_FAR:   far_reg   <= cfg_data[fbb_pkg::REG_W-1:0];
                fbb_pkg::REG_TAN_H: tan_h_reg <= cfg_data[fbb_pkg::REG_W-1:0];
                fbb_pkg::REG_TAN_W: tan_w_reg <= cfg_data[fbb_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int s = NS - 2; s >= 0; s--)
            en[s] = !v_reg[s] || en[s+1];
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = out_data_reg;

    // Move valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
                if (en[s])
                    v_reg[s] <= v_reg[s-1];
        end
    end

    // Stage 0: cross-product terms, centre and offset products
    always_comb
    begin
        logic signed [QW-1:0] up_v    [3];
        logic signed [QW-1:0] fwd_v   [3];
        logic signed [QW-1:0] plane_d [2];
        logic signed [QW-1:0] tw;
        logic signed [QW-1:0] th;
        up_v[0]  = in_data.up_x;
        up_v[1]  = in_data.up_y;
        up_v[2]  = in_data.up_z;
        fwd_v[0] = in_data.fwd_x;
        fwd_v[1] = in_data.fwd_y;
        fwd_v[2] = in_data.fwd_z;
        plane_d[0] = {1'b0, near_reg};
        plane_d[1] = {1'b0, far_reg};
        tw       = {1'b0, tan_w_reg};
        th       = {1'b0, tan_h_reg};
        cx_next[0] = up_v[1] * fwd_v[2];
        cx_next[1] = up_v[2] * fwd_v[1];
        cx_next[2] = up_v[2] * fwd_v[0];
        cx_next[3] = up_v[0] * fwd_v[2];
        cx_next[4] = up_v[0] * fwd_v[1];
        cx_next[5] = up_v[1] * fwd_v[0];
        for (int p = 0; p < 2; p++)
        begin
            for (int k = 0; k < 3; k++)
                fd_next[p][k] = fwd_v[k] * plane_d[p];
            ofl_next[p] = plane_d[p] * tw;
            ofu_next[p] = plane_d[p] * th;
        end
        pos0_next[0] = in_data.pos_x;
        pos0_next[1] = in_data.pos_y;
        pos0_next[2] = in_data.pos_z;
        up0_next     = up_v;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cx_reg   <= cx_next;
            fd_reg   <= fd_next;
            ofl_reg  <= ofl_next;
            ofu_reg  <= ofu_next;
            pos0_reg <= pos0_next;
            up0_reg  <= up0_next;
        end
    end

    // Stage 1: reduce to left vector, plane centres and offsets
    always_comb
    begin
        logic signed [QW-1:0] fterm;
        fterm = '0;
        for (int k = 0; k < 3; k++)
            left1_next[k] = fbb_pkg::sat_shift((PW+1)'(cx_reg[2*k]) - (PW+1)'(cx_reg[2*k+1]));
        for (int p = 0; p < 2; p++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                fterm = fbb_pkg::sat_shift((PW+1)'(fd_reg[p][k]));
                cen1_next[p][k] = fbb_pkg::sat_sum((QW+2)'(pos0_reg[k]) + (QW+2)'(fterm));
            end
            offl1_next[p] = fbb_pkg::sat_shift((PW+1)'(ofl_reg[p]));
            offu1_next[p] = fbb_pkg::sat_shift((PW+1)'(ofu_reg[p]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            left1_reg <= left1_next;
            cen1_reg  <= cen1_next;
            offl1_reg <= offl1_next;
            offu1_reg <= offu1_next;
            up1_reg   <= up0_reg;
        end
    end

    // Stage 2: scale left and up by the plane offsets
    always_comb
    begin
        for (int p = 0; p < 2; p++)
            for (int k = 0; k < 3; k++)
            begin
                ltp2_next[p][k] = left1_reg[k] * offl1_reg[p];
                utp2_next[p][k] = up1_reg[k] * offu1_reg[p];
            end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ltp2_reg <= ltp2_next;
            utp2_reg <= utp2_next;
            cen2_reg <= cen1_reg;
        end
    end

    // Stage 3: shift and saturate the offset terms
    always_comb
    begin
        for (int p = 0; p < 2; p++)
            for (int k = 0; k < 3; k++)
            begin
                lt3_next[p][k] = fbb_pkg::sat_shift((PW+1)'(ltp2_reg[p][k]));
                ut3_next[p][k] = fbb_pkg::sat_shift((PW+1)'(utp2_reg[p][k]));
            end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            lt3_reg  <= lt3_next;
            ut3_reg  <= ut3_next;
            cen3_reg <= cen2_reg;
        end
    end

    // Stage 4: form the eight corners per axis, each saturated once
    always_comb
    begin
        logic signed [QW+1:0] c;
        logic signed [QW+1:0] l;
        logic signed [QW+1:0] u;
        c = '0;
        l = '0;
        u = '0;
        for (int k = 0; k < 3; k++)
            for (int p = 0; p < 2; p++)
            begin
                c = (QW+2)'(cen3_reg[p][k]);
                l = (QW+2)'(lt3_reg[p][k]);
                u = (QW+2)'(ut3_reg[p][k]);
                cor4_next[k][p*4 + 0] = fbb_pkg::sat_sum(c - l - u);
                cor4_next[k][p*4 + 1] = fbb_pkg::sat_sum(c - l + u);
                cor4_next[k][p*4 + 2] = fbb_pkg::sat_sum(c + l - u);
                cor4_next[k][p*4 + 3] = fbb_pkg::sat_sum(c + l + u);
            end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
            cor4_reg <= cor4_next;
    end

    // Stage 5: reduce each group of four corners to a min and a max
    always_comb
    begin
        logic signed [QW-1:0] a;
        logic signed [QW-1:0] b;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        a = '0;
        b = '0;
        x = '0;
        y = '0;
        for (int k = 0; k < 3; k++)
            for (int h = 0; h < 2; h++)
            begin
                a = (cor4_reg[k][h*4]   < cor4_reg[k][h*4+1]) ? cor4_reg[k][h*4]
                                                              : cor4_reg[k][h*4+1];
                b = (cor4_reg[k][h*4+2] < cor4_reg[k][h*4+3]) ? cor4_reg[k][h*4+2]
                                                              : cor4_reg[k][h*4+3];
                x = (cor4_reg[k][h*4]   > cor4_reg[k][h*4+1]) ? cor4_reg[k][h*4]
                                                              : cor4_reg[k][h*4+1];
                y = (cor4_reg[k][h*4+2] > cor4_reg[k][h*4+3]) ? cor4_reg[k][h*4+2]
                                                              : cor4_reg[k][h*4+3];
                lo5_next[k][h] = (a < b) ? a : b;
                hi5_next[k][h] = (x > y) ? x : y;
            end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            lo5_reg <= lo5_next;
            hi5_reg <= hi5_next;
        end
    end

    // Stage 6: final min/max into the output register
    always_comb
    begin
        out_data_next.min_x = (lo5_reg[0][0] < lo5_reg[0][1]) ? lo5_reg[0][0] : lo5_reg[0][1];
        out_data_next.min_y = (lo5_reg[1][0] < lo5_reg[1][1]) ? lo5_reg[1][0] : lo5_reg[1][1];
        out_data_next.min_z = (lo5_reg[2][0] < lo5_reg[2][1]) ? lo5_reg[2][0] : lo5_reg[2][1];
        out_data_next.max_x = (hi5_reg[0][0] > hi5_reg[0][1]) ? hi5_reg[0][0] : hi5_reg[0][1];
        out_data_next.max_y = (hi5_reg[1][0] > hi5_reg[1][1]) ? hi5_reg[1][0] : hi5_reg[1][1];
        out_data_next.max_z = (hi5_reg[2][0] > hi5_reg[2][1]) ? hi5_reg[2][0] : hi5_reg[2][1];
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
            out_data_reg <= out_data_next;
    end

    // Check the pipeline control and the reduction
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v_reg[0])
        else $error("accepted item did not enter the first stage");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&v_reg) && out_stall)
        else $error("input stalled while the pipeline has a free stage");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS-2] && !en[NS-2] |=> v_reg[NS-2])
        else $error("held stage lost its item");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(out_data.min_x) <= $signed(out_data.max_x)) &&
                      ($signed(out_data.min_y) <= $signed(out_data.max_y)) &&
                      ($signed(out_data.min_z) <= $signed(out_data.max_z)))
        else $error("box minimum exceeds maximum");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for frustum_bounding_box_top: random camera poses and
// frustum settings against a fixed-point box predictor kept in a scoreboard class.
// Depends on fbb_pkg for payload structs, register codes and the Q format.
module testbench;

    localparam int FRAC_BITS  = fbb_pkg::FRAC_BITS;
    localparam int Q_W        = fbb_pkg::Q_W;
    localparam int REG_W      = fbb_pkg::REG_W;
    localparam int CFG_IDX_W  = fbb_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = fbb_pkg::CFG_DATA_W;
    localparam int NUM_STAGES = fbb_pkg::NUM_STAGES;
    localparam logic signed [Q_W-1:0] Q_MAX = fbb_pkg::Q_MAX;
    localparam logic signed [Q_W-1:0] Q_MIN = fbb_pkg::Q_MIN;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int LIMIT_NS      = 400_000;
    localparam int IDLE_PERCENT  = 23;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 75;
    localparam int BURST_CYCLES  = 80;
    localparam int NUM_FIELDS_IN = 9;
    localparam int NUM_FIELDS_OUT = 6;
    localparam logic [Q_W-1:0] ONE = Q_W'(64'd1 << FRAC_BITS);

    // Frustum box predictor and the boxes still owed by the block
    class box_scoreboard;
        logic [REG_W-1:0]   near_d;
        logic [REG_W-1:0]   far_d;
        logic [REG_W-1:0]   tan_h;
        logic [REG_W-1:0]   tan_w;
        fbb_pkg::box_item_t boxes_due[$];
        int                 errors;
        int                 boxes_checked;
        string              field_names[NUM_FIELDS_OUT];

        function new();
            near_d = fbb_pkg::NEAR_RESET;
            far_d  = fbb_pkg::FAR_RESET;
            tan_h  = fbb_pkg::TAN_H_RESET;
            tan_w  = fbb_pkg::TAN_W_RESET;
            errors = 0;
            boxes_checked = 0;
            field_names = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};
        endfunction

        // Clamp to the signed Q range
        function longint sat_q(longint v);
            if (v > longint'(Q_MAX))
                return longint'(Q_MAX);
            if (v < longint'(Q_MIN))
                return longint'(Q_MIN);
            return v;
        endfunction

        // Exact product, floor shift, clamp
        function longint mul_q(longint a, longint b);
            return sat_q((a * b) >>> FRAC_BITS);
        endfunction

        // Mirror a register write; drop unknown indexes and bit 31
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                fbb_pkg::REG_NEAR:  near_d = data[REG_W-1:0];
                fbb_pkg::REG_FAR:   far_d  = data[REG_W-1:0];
                fbb_pkg::REG_TAN_H: tan_h  = data[REG_W-1:0];
                fbb_pkg::REG_TAN_W: tan_w  = data[REG_W-1:0];
                default:   ;
            endcase
        endfunction

        function fbb_pkg::box_item_t predict_box(fbb_pkg::cam_item_t c);
            longint    pos[3];
            longint    up[3];
            longint    fwd[3];
            longint    side[3];
            longint    plane_d[2];
            longint    off_side[2];
            longint    off_up[2];
            longint    lo[3];
            longint    hi[3];
            longint    centre;
            longint    side_term;
            longint    up_term;
            longint    corner;
            int        p;
            int        k;
            int        sl;
            int        su;
            fbb_pkg::box_item_t b;

            pos[0] = c.pos_x;
            pos[1] = c.pos_y;
            pos[2] = c.pos_z;
            up[0]  = c.up_x;
            up[1]  = c.up_y;
            up[2]  = c.up_z;
            fwd[0] = c.fwd_x;
            fwd[1] = c.fwd_y;
            fwd[2] = c.fwd_z;

            // Left axis = up x forward, each component reduced exactly then shifted
            side[0] = sat_q((up[1] * fwd[2] - up[2] * fwd[1]) >>> FRAC_BITS);
            side[1] = sat_q((up[2] * fwd[0] - up[0] * fwd[2]) >>> FRAC_BITS);
            side[2] = sat_q((up[0] * fwd[1] - up[1] * fwd[0]) >>> FRAC_BITS);

            // Half extents of the near and far planes
            plane_d[0] = longint'(near_d);
            plane_d[1] = longint'(far_d);
            for (p = 0; p < 2; p++)
            begin
                off_side[p] = mul_q(plane_d[p], longint'(tan_w));
                off_up[p]   = mul_q(plane_d[p], longint'(tan_h));
            end

            for (k = 0; k < 3; k++)
            begin
                lo[k] = longint'(Q_MAX);
                hi[k] = longint'(Q_MIN);
            end

            // Sweep the four corners of each plane, axis by axis
            for (p = 0; p < 2; p++)
            begin
                for (k = 0; k < 3; k++)
                begin
                    centre    = sat_q(pos[k] + mul_q(fwd[k], plane_d[p]));
                    side_term = mul_q(side[k], off_side[p]);
                    up_term   = mul_q(up[k], off_up[p]);
                    for (sl = -1; sl <= 1; sl += 2)
                    begin
                        for (su = -1; su <= 1; su += 2)
                        begin
                            corner = sat_q(centre + sl * side_term + su * up_term);
                            if (corner < lo[k])
                                lo[k] = corner;
                            if (corner > hi[k])
                                hi[k] = corner;
                        end
                    end
                end
            end

            b.min_x = lo[0][Q_W-1:0];
            b.min_y = lo[1][Q_W-1:0];
            b.min_z = lo[2][Q_W-1:0];
            b.max_x = hi[0][Q_W-1:0];
            b.max_y = hi[1][Q_W-1:0];
            b.max_z = hi[2][Q_W-1:0];
            return b;
        endfunction

        function void note_camera(fbb_pkg::cam_item_t c);
            boxes_due.push_back(predict_box(c));
        endfunction

        // Compare a returned box with the oldest one owed
        function void check_box(fbb_pkg::box_item_t got);
            fbb_pkg::box_item_t want;
            logic [Q_W-1:0]     w;
            logic [Q_W-1:0]     g;
            if (boxes_due.size() == 0)
            begin
                errors++;
                $error("box item arrived with no camera item outstanding");
                return;
            end
            want = boxes_due.pop_front();
            boxes_checked++;
            for (int f = 0; f < NUM_FIELDS_OUT; f++)
            begin
                w = want[(NUM_FIELDS_OUT-1-f)*Q_W +: Q_W];
                g = got[(NUM_FIELDS_OUT-1-f)*Q_W +: Q_W];
                if (w !== g)
                begin
                    errors++;
                    $error("%s: expected %0d, actual %0d", field_names[f], $signed(w), $signed(g));
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    fbb_pkg::cam_item_t    in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    fbb_pkg::box_item_t    out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    box_scoreboard board;
    bit            quiet = 1'b0;
    int            burst_count = 0;
    int            items_sent = 0;
    int            settings_used = 1;

    frustum_bounding_box_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Hard stop
    initial
    begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: check each accepted box, stall at random or for a long burst
    initial
    begin : receiver
        int hold_left;
        int bursts_seen;
        hold_left = 0;
        bursts_seen = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_box(out_data);
            if (burst_count != bursts_seen)
            begin
                bursts_seen = burst_count;
                hold_left = BURST_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Offer one camera item, idling first at random; valid stays up afterwards
    task automatic send_camera(input fbb_pkg::cam_item_t cam);
        while (!quiet && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cam;
        do
            @(posedge clk);
        while (in_stall);
        board.note_camera(cam);
        items_sent++;
    endtask

    // Hold valid on the register port until the write is taken
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    // Load all four registers plus one write to an unmapped index
    task automatic set_frustum(input logic [CFG_DATA_W-1:0] nd, input logic [CFG_DATA_W-1:0] fd,
                               input logic [CFG_DATA_W-1:0] th, input logic [CFG_DATA_W-1:0] tw);
        cfg_write(fbb_pkg::REG_NEAR, nd);
        cfg_write(fbb_pkg::REG_FAR, fd);
        cfg_write(fbb_pkg::REG_TAN_H, th);
        cfg_write(fbb_pkg::REG_TAN_W, tw);
        cfg_write(CFG_IDX_W'($urandom_range(int'(fbb_pkg::REG_TAN_W) + 1, 255)), $urandom());
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Drop valid and wait for every owed box
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (board.boxes_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic fbb_pkg::cam_item_t make_cam(
        input logic [Q_W-1:0] px, input logic [Q_W-1:0] py, input logic [Q_W-1:0] pz,
        input logic [Q_W-1:0] ux, input logic [Q_W-1:0] uy, input logic [Q_W-1:0] uz,
        input logic [Q_W-1:0] fx, input logic [Q_W-1:0] fy, input logic [Q_W-1:0] fz);
        fbb_pkg::cam_item_t c;
        c = {px, py, pz, ux, uy, uz, fx, fy, fz};
        return c;
    endfunction

    // Uniform signed value in [-span, span]
    function automatic logic [Q_W-1:0] rand_signed(input int unsigned span);
        return Q_W'($urandom_range(0, 2 * span)) - Q_W'(span);
    endfunction

    // Limits, zero, tiny and raw bits
    function automatic logic [Q_W-1:0] rand_edge();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return rand_signed(4 * ONE);
            default: return $urandom();
        endcase
    endfunction

    // Mostly plausible poses, the rest noise across the full range
    function automatic fbb_pkg::cam_item_t rand_camera();
        fbb_pkg::cam_item_t c;
        bit                 plausible;
        plausible = $urandom_range(0, 99) < 70;
        for (int f = 0; f < NUM_FIELDS_IN; f++)
        begin
            if (!plausible)
                c[(NUM_FIELDS_IN-1-f)*Q_W +: Q_W] = rand_edge();
            else if (f < 3)
                c[(NUM_FIELDS_IN-1-f)*Q_W +: Q_W] = rand_signed(1000 * ONE);
            else
                c[(NUM_FIELDS_IN-1-f)*Q_W +: Q_W] = rand_signed(2 * ONE);
        end
        return c;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_reg_edge();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Unit pose, offsets, zero, limits, parallel and non-unit vectors
    task automatic send_corner_cases();
        send_camera(make_cam(0, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_camera(make_cam(10 * ONE, -(5 * ONE), 3 * ONE, 0, ONE, 0, ONE, 0, 0));
        send_camera(make_cam(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_camera(make_cam(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_camera(make_cam(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_camera(make_cam(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN));
        send_camera(make_cam(ONE, 2 * ONE, 3 * ONE, 0, ONE, 0, 0, 3 * ONE, 0));
        send_camera(make_cam(0, 0, 0, 0, 4 * ONE, ONE, -(3 * ONE), 0, 7 * ONE));
    endtask

    initial
    begin : stimulus
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, then far below near, then the opposite extremes
        send_corner_cases();
        finish_phase();
        set_frustum(32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_corner_cases();
        finish_phase();
        set_frustum(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
        send_corner_cases();
        finish_phase();

        // Random phases, each under its own frustum setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                2, 5:
                    set_frustum($urandom(), $urandom(), $urandom(), $urandom());
                3:
                    set_frustum(rand_reg_edge(), rand_reg_edge(), rand_reg_edge(),
                                rand_reg_edge());
                default:
                    set_frustum($urandom_range(ONE / 20, 10 * ONE),
                                $urandom_range(10 * ONE, 2000 * ONE),
                                $urandom_range(ONE / 20, 4 * ONE),
                                $urandom_range(ONE / 20, 4 * ONE));
            endcase
            quiet = (phase == 0);
            if (phase == 1 || phase == 4)
                burst_count++;
            repeat (PHASE_ITEMS) send_camera(rand_camera());
            finish_phase();
        end
        quiet = 1'b0;

        repeat (2 * NUM_STAGES) @(posedge clk);
        $display("Sent %0d camera items under %0d frustum settings",
                 items_sent, settings_used);
        $display("%0d boxes checked, %0d mismatches", board.boxes_checked, board.errors);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
hdl/fbb_pkg.sv
hdl/frustum_bounding_box_top.sv
dv/testbench.sv
